/* hw/rtl/bipartite_matching_vertex_cover_assert.svh */
// Assertion macros for the bipartite matching and vertex cover RTL.
`ifndef BIPARTITE_MATCHING_VERTEX_COVER_ASSERT_SVH
`define BIPARTITE_MATCHING_VERTEX_COVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMVC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bmvc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BMVC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bmvc assertion failed");

`endif

/* hw/rtl/bmvc_pkg.sv */
// Types and constants of the bipartite matching and vertex cover block.
package bmvc_pkg;

  localparam int MaxVerticesDef = 32;
  localparam int VertexW        = 5;
  localparam int SizeW          = 6;
  localparam int CfgW           = 6;
  localparam logic [CfgW-1:0] NumVerticesRst = 6'd32;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_ADD_RUN = 2'd1,
    CMD_RUN     = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [VertexW-1:0] left_vertex;
    logic [VertexW-1:0] right_vertex;
  } in_item_t;

  typedef struct packed {
    logic               cover_side;
    logic [VertexW-1:0] cover_vertex;
    logic [SizeW-1:0]   matching_size;
    logic               cover_empty;
    logic               last_result;
  } res_item_t;

  // Control of the adjacency memory.
  typedef struct packed {
    logic we;
    logic clear;
  } adj_ctrl_t;

endpackage

/* hw/rtl/bmvc_if.sv */
// Valid/ready channel interfaces for edge commands and cover results.
interface bmvc_in_if;
  logic               valid;
  logic               ready;
  bmvc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bmvc_out_if;
  logic                valid;
  logic                ready;
  bmvc_pkg::res_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/bipartite_matching_vertex_cover.sv */
// Top level of the bipartite matching and minimum vertex cover block.
// Edge commands are taken one per cycle while the block is loading. A run
// command starts Kuhn's augmenting-path search and then Koenig's alternating
// walk; input is held off until the cover has been handed to the result
// register. Every neighbour probe waits on the registered read of the
// partner memory, every frame entry and every resumption goes round the
// registered adjacency read, and every unwound level waits on the stack
// read. The adjacency is cleared through per-row valid bits when the last
// result enters the output register. Results leave through a one-entry
// output register, so a run may end while its last transaction is still
// waiting to be taken.
module bipartite_matching_vertex_cover #(
  parameter int MaxVertices = bmvc_pkg::MaxVerticesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bmvc_in_if.sink                   in_i,
  bmvc_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [bmvc_pkg::CfgW-1:0] cfg_wdata_i
);
  import bmvc_pkg::*;

  localparam int AW   = $clog2(MaxVertices);
  localparam int NW   = $clog2(MaxVertices + 1);
  localparam int CmpW = (NW > CfgW) ? NW : CfgW;

  logic [CfgW-1:0]        num_vertices_q;
  logic [NW-1:0]          n_act;
  adj_ctrl_t              adj_ctrl;
  logic [AW-1:0]          adj_wrow, adj_wbit, adj_raddr;
  logic [MaxVertices-1:0] adj_rdata;
  logic                   res_valid, res_ready;
  res_item_t              res_item;
  logic                   out_valid_q;
  res_item_t              out_data_q;

  // Vertex count register; the count in use is capped at the array size.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vertices_q <= NumVerticesRst;
    end else if (cfg_we_i) begin
      num_vertices_q <= cfg_wdata_i;
    end
  end
  assign n_act = (CmpW'(num_vertices_q) > CmpW'(MaxVertices)) ?
                 NW'(MaxVertices) : NW'(num_vertices_q);

  bmvc_adj_mem #(.MaxV(MaxVertices), .AW(AW)) u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (adj_ctrl),
    .wrow_i  (adj_wrow),
    .wbit_i  (adj_wbit),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  bmvc_core #(.MaxV(MaxVertices), .AW(AW), .NW(NW)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .n_i         (n_act),
    .adj_ctrl_o  (adj_ctrl),
    .adj_wrow_o  (adj_wrow),
    .adj_wbit_o  (adj_wbit),
    .adj_raddr_o (adj_raddr),
    .adj_rdata_i (adj_rdata),
    .res_valid_o (res_valid),
    .res_o       (res_item),
    .res_ready_i (res_ready)
  );

  // Output register decoupling the core from the result sink.
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_item;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

/* hw/rtl/bmvc_adj_mem.sv */
// Adjacency bit matrix: one row per left vertex, bit writes, row valid bits.
module bmvc_adj_mem #(
  parameter int MaxV = bmvc_pkg::MaxVerticesDef,
  parameter int AW   = $clog2(MaxV)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmvc_pkg::adj_ctrl_t ctrl_i,
  input  logic [AW-1:0]       wrow_i,
  input  logic [AW-1:0]       wbit_i,
  input  logic [AW-1:0]       raddr_i,
  output logic [MaxV-1:0]     rdata_o
);
  import bmvc_pkg::*;

  logic [MaxV-1:0] mem [MaxV];
  logic [MaxV-1:0] row_valid_q;
  logic [MaxV-1:0] rdata_q;

  // A row that is not valid reads as cleared; its first write replaces it whole.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
    end else if (ctrl_i.clear) begin
      row_valid_q <= '0;
    end else if (ctrl_i.we) begin
      row_valid_q[wrow_i] <= 1'b1;
    end
  end

  // Memory array with bit-enabled write and a registered read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      if (row_valid_q[wrow_i]) begin
        mem[wrow_i][wbit_i] <= 1'b1;
      end else begin
        mem[wrow_i] <= MaxV'(1) << wbit_i;
      end
    end
    rdata_q <= row_valid_q[raddr_i] ? mem[raddr_i] : '0;
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bmvc_core.sv */
// Augmenting-path search, alternating walk and cover emission around the memories.
module bmvc_core #(
  parameter int MaxV = bmvc_pkg::MaxVerticesDef,
  parameter int AW   = $clog2(MaxV),
  parameter int NW   = $clog2(MaxV + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bmvc_in_if.sink              in_i,
  input  logic [NW-1:0]        n_i,
  output bmvc_pkg::adj_ctrl_t  adj_ctrl_o,
  output logic [AW-1:0]        adj_wrow_o,
  output logic [AW-1:0]        adj_wbit_o,
  output logic [AW-1:0]        adj_raddr_o,
  input  logic [MaxV-1:0]      adj_rdata_i,
  output logic                 res_valid_o,
  output bmvc_pkg::res_item_t  res_o,
  input  logic                 res_ready_i
);
  import bmvc_pkg::*;

  localparam int CmpW = (NW > CfgW) ? NW : CfgW;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_INIT   = 14'b00000000000010,
    S_MSTART = 14'b00000000000100,
    S_ROWREQ = 14'b00000000001000,
    S_ROWWT  = 14'b00000000010000,
    S_SCAN   = 14'b00000000100000,
    S_PARTWT = 14'b00000001000000,
    S_POPWT  = 14'b00000010000000,
    S_UNW    = 14'b00000100000000,
    S_UNWWT  = 14'b00001000000000,
    S_CSTART = 14'b00010000000000,
    S_EREQ   = 14'b00100000000000,
    S_ECHK   = 14'b01000000000000,
    S_EEND   = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic mode_q, mode_d;             // 0 matching search, 1 alternating walk
  logic first_q, first_d;           // frame scans its row from the start
  logic side_q, side_d;             // emission side: 0 left, 1 right
  logic pend_q, pend_d;             // a cover vertex waits for emission
  logic pend_side_q, pend_side_d;
  logic [AW-1:0] pend_v_q, pend_v_d;
  logic [NW-1:0] i_q, i_d;
  logic [NW-1:0] sp_q, sp_d;
  logic [NW-1:0] size_q, size_d;
  logic [AW-1:0] cur_v_q, cur_v_d;
  logic [AW-1:0] cur_to_q, cur_to_d;
  logic [MaxV-1:0] row_q, row_d;
  logic [MaxV-1:0] visited_q, visited_d;
  logic [MaxV-1:0] lreach_q, lreach_d;
  logic [MaxV-1:0] rreach_q, rreach_d;
  logic [MaxV-1:0] lmatch_q, lmatch_d;
  logic [MaxV-1:0] pv_q, pv_d;

  logic [AW-1:0]   part_mem [MaxV];
  logic [2*AW-1:0] stack_mem [MaxV];
  logic [AW-1:0]   part_rd_q;
  logic [2*AW-1:0] stk_rd_q;
  logic            part_we, push;

  logic [MaxV-1:0] nmask, gtmask;
  logic            found;
  logic [AW-1:0]   first_bit;
  logic [NW-1:0]   spm1;
  logic [AW-1:0]   i_idx;
  logic [CmpW-1:0] lx, rx, nx, vx, sx;
  logic            in_range, accept, cand;
  res_item_t       res_item;

  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign spm1  = sp_q - NW'(1);
  assign i_idx = i_q[AW-1:0];

  // Edge range check against the vertex count in use.
  assign lx = CmpW'(in_i.data.left_vertex);
  assign rx = CmpW'(in_i.data.right_vertex);
  assign nx = CmpW'(n_i);
  assign in_range = (lx < nx) && (rx < nx);
  assign adj_wrow_o = lx[AW-1:0];
  assign adj_wbit_o = rx[AW-1:0];

  // Column masks: columns in use, and columns after the one last tried.
  always_comb begin
    for (int j = 0; j < MaxV; j++) begin
      nmask[j]  = (NW'(j) < n_i);
      gtmask[j] = (AW'(j) > cur_to_q);
    end
  end

  // Lowest remaining neighbour of the current frame.
  always_comb begin
    found     = 1'b0;
    first_bit = '0;
    for (int j = MaxV - 1; j >= 0; j--) begin
      if (row_q[j]) begin
        found     = 1'b1;
        first_bit = AW'(j);
      end
    end
  end

  // Partner and stack memories, each with a registered read.
  always_ff @(posedge clk_i) begin
    if (part_we) begin
      part_mem[cur_to_q] <= cur_v_q;
    end
    part_rd_q <= part_mem[first_bit];
    if (push) begin
      stack_mem[sp_q[AW-1:0]] <= {cur_v_q, cur_to_q};
    end
    stk_rd_q <= stack_mem[spm1[AW-1:0]];
  end

  // Cover candidate at the emission index.
  always_comb begin
    if (side_q) begin
      cand = rreach_q[i_idx];
    end else begin
      cand = !lreach_q[i_idx] && ((adj_rdata_i & nmask) != '0);
    end
  end

  // Result payload from the pending vertex, or an empty-cover marker at the end.
  assign vx = CmpW'(pend_v_q);
  assign sx = CmpW'(size_q);
  always_comb begin
    res_item.cover_side    = pend_side_q;
    res_item.cover_vertex  = vx[VertexW-1:0];
    res_item.matching_size = sx[SizeW-1:0];
    res_item.cover_empty   = 1'b0;
    res_item.last_result   = (state_q == S_EEND);
    if (state_q == S_EEND && !pend_q) begin
      res_item = '0;
      res_item.cover_empty = 1'b1;
      res_item.last_result = 1'b1;
    end
  end
  assign res_o = res_item;
  assign res_valid_o = (state_q == S_EEND) || ((state_q == S_ECHK) && cand && pend_q);

  assign adj_raddr_o = (state_q == S_EREQ || state_q == S_ECHK) ? i_idx : cur_v_q;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    first_d     = first_q;
    side_d      = side_q;
    pend_d      = pend_q;
    pend_side_d = pend_side_q;
    pend_v_d    = pend_v_q;
    i_d         = i_q;
    sp_d        = sp_q;
    size_d      = size_q;
    cur_v_d     = cur_v_q;
    cur_to_d    = cur_to_q;
    row_d       = row_q;
    visited_d   = visited_q;
    lreach_d    = lreach_q;
    rreach_d    = rreach_q;
    lmatch_d    = lmatch_q;
    pv_d        = pv_q;
    part_we     = 1'b0;
    push        = 1'b0;
    adj_ctrl_o  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((in_i.data.cmd == CMD_ADD || in_i.data.cmd == CMD_ADD_RUN) && in_range) begin
            adj_ctrl_o.we = 1'b1;
          end
          if (in_i.data.cmd == CMD_ADD_RUN || in_i.data.cmd == CMD_RUN) begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        pv_d     = '0;
        lmatch_d = '0;
        lreach_d = '0;
        rreach_d = '0;
        size_d   = '0;
        i_d      = '0;
        mode_d   = 1'b0;
        state_d  = S_MSTART;
      end
      S_MSTART: begin
        if (i_q >= n_i) begin
          mode_d  = 1'b1;
          i_d     = '0;
          state_d = S_CSTART;
        end else begin
          visited_d        = '0;
          visited_d[i_idx] = 1'b1;
          cur_v_d          = i_idx;
          sp_d             = '0;
          first_d          = 1'b1;
          state_d          = S_ROWREQ;
        end
      end
      S_ROWREQ: begin
        state_d = S_ROWWT;
      end
      S_ROWWT: begin
        row_d   = adj_rdata_i & nmask & (first_q ? '1 : gtmask);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (found) begin
          cur_to_d         = first_bit;
          row_d[first_bit] = 1'b0;
          state_d          = S_PARTWT;
        end else if (sp_q == '0) begin
          i_d     = i_q + NW'(1);
          state_d = mode_q ? S_CSTART : S_MSTART;
        end else begin
          state_d = S_POPWT;
        end
      end
      S_PARTWT: begin
        if (!mode_q) begin
          if (!pv_q[cur_to_q]) begin
            state_d = S_UNW;
          end else if (visited_q[part_rd_q]) begin
            state_d = S_SCAN;
          end else begin
            push                 = 1'b1;
            sp_d                 = sp_q + NW'(1);
            cur_v_d              = part_rd_q;
            visited_d[part_rd_q] = 1'b1;
            first_d              = 1'b1;
            state_d              = S_ROWREQ;
          end
        end else begin
          rreach_d[cur_to_q] = 1'b1;
          if (pv_q[cur_to_q] && !lreach_q[part_rd_q]) begin
            push                = 1'b1;
            sp_d                = sp_q + NW'(1);
            cur_v_d             = part_rd_q;
            lreach_d[part_rd_q] = 1'b1;
            first_d             = 1'b1;
            state_d             = S_ROWREQ;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_POPWT: begin
        {cur_v_d, cur_to_d} = stk_rd_q;
        sp_d                = spm1;
        first_d             = 1'b0;
        state_d             = S_ROWREQ;
      end
      S_UNW: begin
        part_we        = 1'b1;
        pv_d[cur_to_q] = 1'b1;
        if (sp_q == '0) begin
          lmatch_d[i_idx] = 1'b1;
          size_d          = size_q + NW'(1);
          i_d             = i_q + NW'(1);
          state_d         = S_MSTART;
        end else begin
          state_d = S_UNWWT;
        end
      end
      S_UNWWT: begin
        {cur_v_d, cur_to_d} = stk_rd_q;
        sp_d                = spm1;
        state_d             = S_UNW;
      end
      S_CSTART: begin
        if (i_q >= n_i) begin
          i_d     = '0;
          side_d  = 1'b0;
          pend_d  = 1'b0;
          state_d = S_EREQ;
        end else if (!lmatch_q[i_idx]) begin
          cur_v_d         = i_idx;
          lreach_d[i_idx] = 1'b1;
          sp_d            = '0;
          first_d         = 1'b1;
          state_d         = S_ROWREQ;
        end else begin
          i_d = i_q + NW'(1);
        end
      end
      S_EREQ: begin
        if (i_q >= n_i) begin
          if (!side_q) begin
            side_d = 1'b1;
            i_d    = '0;
          end else begin
            state_d = S_EEND;
          end
        end else begin
          state_d = S_ECHK;
        end
      end
      S_ECHK: begin
        if (!cand) begin
          i_d     = i_q + NW'(1);
          state_d = S_EREQ;
        end else if (!pend_q || res_ready_i) begin
          pend_d      = 1'b1;
          pend_side_d = side_q;
          pend_v_d    = i_idx;
          i_d         = i_q + NW'(1);
          state_d     = S_EREQ;
        end
      end
      S_EEND: begin
        if (res_ready_i) begin
          adj_ctrl_o.clear = 1'b1;
          pend_d           = 1'b0;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= 1'b0;
      first_q   <= 1'b0;
      side_q    <= 1'b0;
      pend_q    <= 1'b0;
      i_q       <= '0;
      sp_q      <= '0;
      size_q    <= '0;
      visited_q <= '0;
      lreach_q  <= '0;
      rreach_q  <= '0;
      lmatch_q  <= '0;
      pv_q      <= '0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      first_q   <= first_d;
      side_q    <= side_d;
      pend_q    <= pend_d;
      i_q       <= i_d;
      sp_q      <= sp_d;
      size_q    <= size_d;
      visited_q <= visited_d;
      lreach_q  <= lreach_d;
      rreach_q  <= rreach_d;
      lmatch_q  <= lmatch_d;
      pv_q      <= pv_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_side_q <= pend_side_d;
    pend_v_q    <= pend_v_d;
    cur_v_q     <= cur_v_d;
    cur_to_q    <= cur_to_d;
    row_q       <= row_d;
  end

`include "bipartite_matching_vertex_cover_assert.svh"

  `BMVC_ASSERT_NOW(a_stack_idle, state_q == S_IDLE, sp_q == '0)
  `BMVC_ASSERT_NOW(a_size_bound, state_q == S_MSTART, size_q <= i_q)
  `BMVC_ASSERT_NOW(a_stack_depth, state_q == S_PARTWT, sp_q < n_i)

endmodule
